[rtl/sit_pkg.sv]
// shared types and constants for the segment intersection test pipeline
// no dependencies; sit_mul, sit_det, sit_ratio and the top refer to it by scoped names
package sit_pkg;

  // register stages from input word to output register
  localparam int NUM_STAGES = 4;

  // per-stage control: load strobe plus the prefilter verdict riding along
  typedef struct packed {
    logic load;
    logic pass;
  } stg_ctl_t;

endpackage : sit_pkg

[rtl/sit_if.sv]
// valid/ready channel interfaces: segment pair input and intersect result
// no dependencies
interface sit_seg_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] p1_x;
  logic signed [COORD_BITS-1:0] p1_y;
  logic signed [COORD_BITS-1:0] p2_x;
  logic signed [COORD_BITS-1:0] p2_y;
  logic signed [COORD_BITS-1:0] q1_x;
  logic signed [COORD_BITS-1:0] q1_y;
  logic signed [COORD_BITS-1:0] q2_x;
  logic signed [COORD_BITS-1:0] q2_y;

  modport source (
    output valid, p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y,
    input  ready
  );
  modport sink (
    input  valid, p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y,
    output ready
  );
endinterface : sit_seg_if

interface sit_res_if;
  logic valid;
  logic ready;
  logic intersects;

  modport source (output valid, intersects, input ready);
  modport sink   (input valid, intersects, output ready);
endinterface : sit_res_if

[rtl/sit_front.sv]
// stage 1: per-axis strict interval prefilter and coordinate differences
// no dependencies
module sit_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic signed [COORD_BITS-1:0] p1_x,
  input  logic signed [COORD_BITS-1:0] p1_y,
  input  logic signed [COORD_BITS-1:0] p2_x,
  input  logic signed [COORD_BITS-1:0] p2_y,
  input  logic signed [COORD_BITS-1:0] q1_x,
  input  logic signed [COORD_BITS-1:0] q1_y,
  input  logic signed [COORD_BITS-1:0] q2_x,
  input  logic signed [COORD_BITS-1:0] q2_y,
  output logic signed [COORD_BITS:0]   dpx_r,
  output logic signed [COORD_BITS:0]   dpy_r,
  output logic signed [COORD_BITS:0]   dqx_r,
  output logic signed [COORD_BITS:0]   dqy_r,
  output logic signed [COORD_BITS:0]   rx_r,
  output logic signed [COORD_BITS:0]   ry_r,
  output logic                         pass_r
);

  localparam int DW = COORD_BITS + 1;

  // x strictly between a and b, either order; empty when a equals b
  function automatic logic strict_in(
    input logic signed [COORD_BITS-1:0] x,
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return ((a < x) && (x < b)) || ((b < x) && (x < a));
  endfunction

  function automatic logic signed [DW-1:0] sdiff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [DW-1:0] ae;
    logic signed [DW-1:0] be;
    ae = DW'(a);
    be = DW'(b);
    return ae - be;
  endfunction

  logic ovl_x;
  logic ovl_y;

  assign ovl_x = strict_in(p1_x, q1_x, q2_x) || strict_in(p2_x, q1_x, q2_x) ||
                 strict_in(q1_x, p1_x, p2_x) || strict_in(q2_x, p1_x, p2_x);
  assign ovl_y = strict_in(p1_y, q1_y, q2_y) || strict_in(p2_y, q1_y, q2_y) ||
                 strict_in(q1_y, p1_y, p2_y) || strict_in(q2_y, p1_y, p2_y);

  always_ff @(posedge clk) begin
    if (load) begin
      dpx_r  <= sdiff(p2_x, p1_x);
      dpy_r  <= sdiff(p2_y, p1_y);
      dqx_r  <= sdiff(q2_x, q1_x);
      dqy_r  <= sdiff(q2_y, q1_y);
      rx_r   <= sdiff(q1_x, p1_x);
      ry_r   <= sdiff(q1_y, p1_y);
      pass_r <= ovl_x & ovl_y;
    end
  end

endmodule : sit_front

[rtl/sit_mul.sv]
// stage 2: the six exact cross products of the three 2x2 determinants
// depends on sit_pkg
module sit_mul #(
  parameter int COORD_BITS = 24
) (
  input  logic                              clk,
  input  sit_pkg::stg_ctl_t                 ctl,
  input  logic signed [COORD_BITS:0]        dpx,
  input  logic signed [COORD_BITS:0]        dpy,
  input  logic signed [COORD_BITS:0]        dqx,
  input  logic signed [COORD_BITS:0]        dqy,
  input  logic signed [COORD_BITS:0]        rx,
  input  logic signed [COORD_BITS:0]        ry,
  output logic signed [2*COORD_BITS+1:0]    a_pos_r,
  output logic signed [2*COORD_BITS+1:0]    a_neg_r,
  output logic signed [2*COORD_BITS+1:0]    l_pos_r,
  output logic signed [2*COORD_BITS+1:0]    l_neg_r,
  output logic signed [2*COORD_BITS+1:0]    m_pos_r,
  output logic signed [2*COORD_BITS+1:0]    m_neg_r,
  output logic                              pass_r
);

  localparam int PW = 2 * COORD_BITS + 2;

  // positive and negative terms of detA, numL, numM
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_pos_r <= PW'(dpx) * PW'(dqy);
      a_neg_r <= PW'(dqx) * PW'(dpy);
      l_pos_r <= PW'(rx) * PW'(dqy);
      l_neg_r <= PW'(dqx) * PW'(ry);
      m_pos_r <= PW'(rx) * PW'(dpy);
      m_neg_r <= PW'(dpx) * PW'(ry);
      pass_r  <= ctl.pass;
    end
  end

endmodule : sit_mul

[rtl/sit_det.sv]
// stage 3: determinant subtractions, exact at the product width plus one
// depends on sit_pkg
module sit_det #(
  parameter int COORD_BITS = 24
) (
  input  logic                           clk,
  input  sit_pkg::stg_ctl_t              ctl,
  input  logic signed [2*COORD_BITS+1:0] a_pos,
  input  logic signed [2*COORD_BITS+1:0] a_neg,
  input  logic signed [2*COORD_BITS+1:0] l_pos,
  input  logic signed [2*COORD_BITS+1:0] l_neg,
  input  logic signed [2*COORD_BITS+1:0] m_pos,
  input  logic signed [2*COORD_BITS+1:0] m_neg,
  output logic signed [2*COORD_BITS+2:0] det_a_r,
  output logic signed [2*COORD_BITS+2:0] num_l_r,
  output logic signed [2*COORD_BITS+2:0] num_m_r,
  output logic                           pass_r
);

  localparam int XW = 2 * COORD_BITS + 3;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      det_a_r <= XW'(a_pos) - XW'(a_neg);
      num_l_r <= XW'(l_pos) - XW'(l_neg);
      num_m_r <= XW'(m_pos) - XW'(m_neg);
      pass_r  <= ctl.pass;
    end
  end

endmodule : sit_det

[rtl/sit_ratio.sv]
// stage 4: both parameters in [0,1] by sign and magnitude against detA,
// result lands in the output register; depends on sit_pkg
module sit_ratio #(
  parameter int COORD_BITS = 24
) (
  input  logic                           clk,
  input  sit_pkg::stg_ctl_t              ctl,
  input  logic signed [2*COORD_BITS+2:0] det_a,
  input  logic signed [2*COORD_BITS+2:0] num_l,
  input  logic signed [2*COORD_BITS+2:0] num_m,
  output logic                           hit_r
);

  localparam int XW = 2 * COORD_BITS + 3;

  // num/den in [0,1] for den nonzero; for two negatives |num|<=|den| is num>=den
  function automatic logic unit_ratio(
    input logic signed [XW-1:0] num,
    input logic signed [XW-1:0] den
  );
    logic res;
    if (num == '0) begin
      res = 1'b1;
    end else if (num[XW-1] != den[XW-1]) begin
      res = 1'b0;
    end else if (den[XW-1]) begin
      res = (num >= den);
    end else begin
      res = (num <= den);
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hit_r <= ctl.pass && (det_a != '0) && unit_ratio(num_l, det_a) &&
               unit_ratio(num_m, det_a);
    end
  end

endmodule : sit_ratio

[rtl/segment_intersection_test_top.sv]
// top level of the segment intersection test: four-stage pipeline
// depends on sit_pkg, sit_if, sit_front, sit_mul, sit_det, sit_ratio
//
//  channel   dir  payload                                 handshake
//  in_seg    in   p1_x p1_y p2_x p2_y q1_x q1_y q2_x q2_y  valid/ready
//  out_res   out  intersects                              valid/ready
//
// one word per cycle sustained while out_res.ready is high; a word's result
// is registered through stage 1 prefilter and differences, stage 2
// multipliers, stage 3 determinant subtract and stage 4 ratio compare into
// the output register, where it can leave once out_res.ready is high
// each stage loads when it is empty or the stage after it moves, so bubbles
// collapse and the input keeps flowing while a result waits at the output,
// until all four stages hold a word; then in_seg.ready drops
// rst_n (synchronous, active low) clears only the valid bits; data is not reset
module segment_intersection_test_top #(
  parameter int COORD_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  sit_seg_if.sink    in_seg,
  sit_res_if.source  out_res
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;
  localparam int NS = sit_pkg::NUM_STAGES;

  // valid bit per stage; the last one is the output register
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] adv;
  logic [NS-1:0] up_vld;

  // stage 1 outputs
  logic signed [DW-1:0] dpx, dpy, dqx, dqy, rx, ry;
  logic                 pass1;
  // stage 2 outputs
  logic signed [PW-1:0] a_pos, a_neg, l_pos, l_neg, m_pos, m_neg;
  logic                 pass2;
  // stage 3 outputs
  logic signed [XW-1:0] det_a, num_l, num_m;
  logic                 pass3;
  logic                 hit;

  sit_pkg::stg_ctl_t ctl2, ctl3, ctl4;

  // a stage advances when it is empty or its successor advances
  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_res.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    up_vld[0] = in_seg.valid;
    for (int i = 1; i < NS; i++) begin
      up_vld[i] = vld_r[i-1];
    end
    for (int i = 0; i < NS; i++) begin
      vld_nxt[i] = adv[i] ? up_vld[i] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_seg.ready = adv[0];

  assign ctl2 = '{load: adv[1], pass: pass1};
  assign ctl3 = '{load: adv[2], pass: pass2};
  assign ctl4 = '{load: adv[3], pass: pass3};

  sit_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk    (clk),
    .load   (adv[0]),
    .p1_x   (in_seg.p1_x),
    .p1_y   (in_seg.p1_y),
    .p2_x   (in_seg.p2_x),
    .p2_y   (in_seg.p2_y),
    .q1_x   (in_seg.q1_x),
    .q1_y   (in_seg.q1_y),
    .q2_x   (in_seg.q2_x),
    .q2_y   (in_seg.q2_y),
    .dpx_r  (dpx),
    .dpy_r  (dpy),
    .dqx_r  (dqx),
    .dqy_r  (dqy),
    .rx_r   (rx),
    .ry_r   (ry),
    .pass_r (pass1)
  );

  sit_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk     (clk),
    .ctl     (ctl2),
    .dpx     (dpx),
    .dpy     (dpy),
    .dqx     (dqx),
    .dqy     (dqy),
    .rx      (rx),
    .ry      (ry),
    .a_pos_r (a_pos),
    .a_neg_r (a_neg),
    .l_pos_r (l_pos),
    .l_neg_r (l_neg),
    .m_pos_r (m_pos),
    .m_neg_r (m_neg),
    .pass_r  (pass2)
  );

  sit_det #(.COORD_BITS(COORD_BITS)) u_det (
    .clk     (clk),
    .ctl     (ctl3),
    .a_pos   (a_pos),
    .a_neg   (a_neg),
    .l_pos   (l_pos),
    .l_neg   (l_neg),
    .m_pos   (m_pos),
    .m_neg   (m_neg),
    .det_a_r (det_a),
    .num_l_r (num_l),
    .num_m_r (num_m),
    .pass_r  (pass3)
  );

  sit_ratio #(.COORD_BITS(COORD_BITS)) u_ratio (
    .clk   (clk),
    .ctl   (ctl4),
    .det_a (det_a),
    .num_l (num_l),
    .num_m (num_m),
    .hit_r (hit)
  );

  assign out_res.valid      = vld_r[NS-1];
  assign out_res.intersects = hit;

`ifndef SYNTHESIS
  // pipeline completely full and output stalled: no new word may enter
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ((&vld_r) && !out_res.ready) |-> !in_seg.ready)
    else $error("input accepted with full stalled pipeline");

  // prefilter reject must reach the output as a miss
  a_reject_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (adv[NS-1] && vld_r[NS-2] && !pass3) |=> !out_res.intersects)
    else $error("prefilter reject produced a hit");

  // parallel or collinear pairs never intersect
  a_parallel_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (adv[NS-1] && vld_r[NS-2] && (det_a == '0)) |=> !out_res.intersects)
    else $error("zero determinant produced a hit");
`endif

endmodule : segment_intersection_test_top

[dv/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for segment_intersection_test_top: drives segment pairs,
// predicts the intersect bit per word and checks every result in order
// depends on rtl/sit_pkg.sv, rtl/sit_if.sv and rtl/segment_intersection_test_top.sv
module tb_top;

  localparam int CB          = 24;
  localparam int WIDE        = 2 * CB + 4;    // holds any determinant without overflow
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;            // long receiver hold-off, fills the pipe
  localparam int PHASE_WORDS = 150;
  localparam int NUM_PHASES  = 5;
  localparam int C_MAX       = 8388607;
  localparam int C_MIN       = -8388608;

  typedef logic signed [CB-1:0]   coord_t;
  typedef logic signed [WIDE-1:0] wide_t;

  // one segment pair plus the idle cycles the sender spends before offering it
  typedef struct {
    coord_t      p1x, p1y, p2x, p2y;
    coord_t      q1x, q1y, q2x, q2y;
    int unsigned gap;
  } seg_word_t;

  logic clk;
  logic rst_n;

  sit_seg_if #(.COORD_BITS(CB)) in_seg ();
  sit_res_if                    out_res ();

  segment_intersection_test_top #(.COORD_BITS(CB)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_seg  (in_seg),
    .out_res (out_res)
  );

  // words waiting for the driver, and the intersect bits predicted for accepted words
  seg_word_t seg_words_pending[$];
  bit        hit_expected[$];

  // driver state
  seg_word_t   word_next;
  bit          word_held;
  int unsigned gap_left;

  // receiver state
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_req;
  bit          exp_hit;

  // idle controls per phase
  bit src_quiet;
  bit snk_quiet;

  int unsigned fail_count;
  int unsigned cycle_count;

  // ---------------------------------------------------------------------------
  // predictor: exact integer geometry at a width that cannot overflow
  // ---------------------------------------------------------------------------

  // v strictly between a and b, whichever order a and b come in
  function automatic bit strictly_between(wide_t v, wide_t a, wide_t b);
    if (a < b) return (a < v) && (v < b);
    return (b < v) && (v < a);
  endfunction

  // prefilter on one axis: some endpoint lies strictly inside the other interval
  function automatic bit axis_overlaps(wide_t a1, wide_t a2, wide_t b1, wide_t b2);
    return strictly_between(a1, b1, b2) || strictly_between(a2, b1, b2) ||
           strictly_between(b1, a1, a2) || strictly_between(b2, a1, a2);
  endfunction

  // num/den within [0,1] without dividing; den is nonzero
  function automatic bit ratio_in_unit(wide_t num, wide_t den);
    wide_t mag_num;
    wide_t mag_den;
    if (num == 0) return 1'b1;
    if ((num < 0) != (den < 0)) return 1'b0;
    mag_num = (num < 0) ? -num : num;
    mag_den = (den < 0) ? -den : den;
    return mag_num <= mag_den;
  endfunction

  function automatic bit seg_cross_predict(seg_word_t w);
    wide_t p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
    wide_t dpx, dpy, dqx, dqy, rx, ry;
    wide_t det_a, num_l, num_m;
    p1x = w.p1x; p1y = w.p1y; p2x = w.p2x; p2y = w.p2y;
    q1x = w.q1x; q1y = w.q1y; q2x = w.q2x; q2y = w.q2y;
    if (!axis_overlaps(p1x, p2x, q1x, q2x) || !axis_overlaps(p1y, p2y, q1y, q2y))
      return 1'b0;
    dpx = p2x - p1x;  dpy = p2y - p1y;
    dqx = q2x - q1x;  dqy = q2y - q1y;
    rx  = q1x - p1x;  ry  = q1y - p1y;
    det_a = dpx * dqy - dqx * dpy;
    num_l = rx * dqy - dqx * ry;
    num_m = rx * dpy - dpx * ry;
    // parallel or collinear never counts as a hit
    if (det_a == 0) return 1'b0;
    return ratio_in_unit(num_l, det_a) && ratio_in_unit(num_m, det_a);
  endfunction

  // ---------------------------------------------------------------------------
  // clock, cycle limit
  // ---------------------------------------------------------------------------
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: offers the pending words one by one, predicts each on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_seg.valid <= 1'b0;
      word_held    = 1'b0;
      gap_left     = 0;
    end else begin
      // word accepted at this edge: the fields on the bus are the ones that count
      if (in_seg.valid && in_seg.ready) begin
        word_next.p1x = in_seg.p1_x;  word_next.p1y = in_seg.p1_y;
        word_next.p2x = in_seg.p2_x;  word_next.p2y = in_seg.p2_y;
        word_next.q1x = in_seg.q1_x;  word_next.q1y = in_seg.q1_y;
        word_next.q2x = in_seg.q2_x;  word_next.q2y = in_seg.q2_y;
        hit_expected.push_back(seg_cross_predict(word_next));
      end
      // bus free: fetch the next word, sit out its gap, then present it
      if (!in_seg.valid || in_seg.ready) begin
        if (!word_held && seg_words_pending.size() > 0) begin
          word_next = seg_words_pending.pop_front();
          gap_left  = word_next.gap;
          word_held = 1'b1;
        end
        if (word_held && gap_left == 0) begin
          in_seg.p1_x  <= word_next.p1x;  in_seg.p1_y <= word_next.p1y;
          in_seg.p2_x  <= word_next.p2x;  in_seg.p2_y <= word_next.p2y;
          in_seg.q1_x  <= word_next.q1x;  in_seg.q1_y <= word_next.q1y;
          in_seg.q2_x  <= word_next.q2x;  in_seg.q2_y <= word_next.q2y;
          in_seg.valid <= 1'b1;
          word_held    = 1'b0;
        end else begin
          in_seg.valid <= 1'b0;
          if (word_held) gap_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor and receiver: checks each result, then stalls a random while;
  // a hold request from the sequence below freezes ready for a long stretch
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      stall_left    = 0;
      hold_left     = 0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        if (hit_expected.size() == 0) begin
          $error("intersects: no result expected, got %0b", out_res.intersects);
          fail_count++;
        end else begin
          exp_hit = hit_expected.pop_front();
          if (out_res.intersects !== exp_hit) begin
            $error("intersects mismatch: expected %0b, got %0b", exp_hit, out_res.intersects);
            fail_count++;
          end
        end
        stall_left = snk_quiet ? 0 : $urandom_range(0, 8);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_res.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // queue one word; coordinates are truncated to the field width
  task automatic queue_seg(input int ax, ay, bx, by, cx, cy, dx, dy);
    seg_word_t w;
    w.p1x = coord_t'(ax);  w.p1y = coord_t'(ay);
    w.p2x = coord_t'(bx);  w.p2y = coord_t'(by);
    w.q1x = coord_t'(cx);  w.q1y = coord_t'(cy);
    w.q2x = coord_t'(dx);  w.q2y = coord_t'(dy);
    w.gap = src_quiet ? 0 : $urandom_range(0, 8);
    seg_words_pending.push_back(w);
  endtask

  function automatic int full_coord();
    return int'(coord_t'($urandom()));
  endfunction

  // tiny grid: equal coordinates, collinear and touching cases show up often
  function automatic int tiny_coord();
    return int'($urandom_range(0, 16)) - 8;
  endfunction

  function automatic int mid_coord(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic queue_random_seg();
    int cx, cy, ux, uy, vx, vy, jx, jy;
    int ax, ay, bx, by;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // anywhere in the full range: sign bits and magnitude bits all toggle
        queue_seg(full_coord(), full_coord(), full_coord(), full_coord(),
                  full_coord(), full_coord(), full_coord(), full_coord());
      end
      3, 4, 5: begin
        queue_seg(tiny_coord(), tiny_coord(), tiny_coord(), tiny_coord(),
                  tiny_coord(), tiny_coord(), tiny_coord(), tiny_coord());
      end
      6, 7, 8: begin
        // both segments centered on one point, the second nudged now and then
        cx = mid_coord(1 << 21);  cy = mid_coord(1 << 21);
        ux = mid_coord(1 << 20);  uy = mid_coord(1 << 20);
        vx = mid_coord(1 << 20);  vy = mid_coord(1 << 20);
        jx = ($urandom_range(0, 1) == 1) ? mid_coord(2) : 0;
        jy = ($urandom_range(0, 1) == 1) ? mid_coord(2) : 0;
        queue_seg(cx + ux, cy + uy, cx - ux, cy - uy,
                  cx + vx + jx, cy + vy + jy, cx - vx + jx, cy - vy + jy);
      end
      default: begin
        // shared endpoint, in either role
        ax = mid_coord(1000);  ay = mid_coord(1000);
        bx = mid_coord(1000);  by = mid_coord(1000);
        if ($urandom_range(0, 1) == 1)
          queue_seg(ax, ay, bx, by, bx, by, mid_coord(1000), mid_coord(1000));
        else
          queue_seg(ax, ay, bx, by, mid_coord(1000), mid_coord(1000), ax, ay);
      end
    endcase
  endtask

  // sampled on the falling edge, clear of the driver and monitor updates
  task automatic wait_drained();
    while (!(seg_words_pending.size() == 0 && !word_held && !in_seg.valid &&
             hit_expected.size() == 0))
      @(negedge clk);
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_seg.valid = 1'b0;
    in_seg.p1_x  = '0;  in_seg.p1_y = '0;
    in_seg.p2_x  = '0;  in_seg.p2_y = '0;
    in_seg.q1_x  = '0;  in_seg.q1_y = '0;
    in_seg.q2_x  = '0;  in_seg.q2_y = '0;
    out_res.ready = 1'b0;
    hold_req     = 1'b0;
    src_quiet    = 1'b0;
    snk_quiet    = 1'b0;
    fail_count   = 0;
    cycle_count  = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed words
    queue_seg(0, 0, 10, 10, 0, 10, 10, 0);                      // plain crossing
    queue_seg(10, 10, 0, 0, 10, 0, 0, 10);                      // same, endpoints swapped
    queue_seg(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN); // full-range diagonals
    queue_seg(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX);
    queue_seg(C_MIN, 0, C_MAX, 0, 0, C_MIN, 0, C_MAX);          // full-range axis cross
    queue_seg(C_MIN + 1, C_MAX - 1, C_MAX, C_MIN, C_MIN, C_MIN + 1, C_MAX - 1, C_MAX);
    queue_seg(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX); // all one point
    queue_seg(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    queue_seg(0, 0, 10, 10, 1, 0, 11, 10);                      // parallel
    queue_seg(0, 0, 10, 10, 5, 5, 15, 15);                      // collinear overlap
    queue_seg(0, -5, 0, 5, -5, 0, 5, 0);                        // degenerate intervals crossing
    queue_seg(0, 3, 10, 3, 5, 3, 15, 3);                        // both flat on one line
    queue_seg(0, 0, 10, 0, 5, 0, 5, 10);                        // touch at interval end only
    queue_seg(0, 0, 10, 10, 10, 10, 20, 0);                     // shared endpoint
    queue_seg(0, 0, 10, 10, 5, 5, 10, 0);                       // zero numerator
    queue_seg(0, 0, 10, 10, 0, 10, 5, 5);                       // parameter exactly one
    queue_seg(0, 0, 4, 4, 0, 10, 10, 0);                        // lines meet past the end
    queue_seg(0, 0, 10, 10, 6, 0, 10, 3);                       // near miss
    queue_seg(-100, -50, -20, -10, -90, -10, -30, -60);         // negative quadrant crossing
    queue_seg(C_MAX, 0, C_MIN, 1, 0, C_MAX, 1, C_MIN);          // steep versus shallow
    wait_drained();                                             // sender pause

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // phase 2 runs with no idling at all; phase 3 floods a frozen receiver
      src_quiet = (ph == 2) || (ph == 3);
      snk_quiet = (ph == 2);
      for (int i = 0; i < PHASE_WORDS; i++) queue_random_seg();
      if (ph == 3) begin
        @(negedge clk);
        hold_req = 1'b1;
      end
      if (ph == 1 || ph == 3) wait_drained();
    end

    wait_drained();
    repeat (sit_pkg::NUM_STAGES + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule : tb_top

[segment_intersection_test_top.f]
rtl/sit_pkg.sv
rtl/sit_if.sv
rtl/sit_front.sv
rtl/sit_mul.sv
rtl/sit_det.sv
rtl/sit_ratio.sv
rtl/segment_intersection_test_top.sv
dv/tb_top.sv
